[sv/alfp_pkg.sv]
// ----------------------------------------------------------------------------
// alfp_pkg
// Shared types, constants and helpers for the linked list node pool
// ----------------------------------------------------------------------------
package alfp_pkg;

    // node store geometry
    localparam int NODE_COUNT = 16;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LINK_W     = $clog2(NODE_COUNT + 1);
    localparam int VALUE_W    = 32;

    // a link equal to the node count stands for null
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODE_COUNT);

    // command codes carried in the input beat
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_POP_FRONT  = 2'd1,
        CMD_PUSH_BACK  = 2'd2
    } t_cmd;

    // status codes of the result beat
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // micro operations the controller asks of the datapath
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_FREE,
        OP_TAKE_FRONT,
        OP_TAKE_BACK,
        OP_RD_HEAD,
        OP_GIVE,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_LINK_LAST,
        OP_RD_FRONT,
        OP_OUT
    } t_dp_op;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_TAKE_RD,
        S_TAKE_WR,
        S_POP_RD,
        S_POP_WR,
        S_WALK_RD,
        S_WALK,
        S_LINK,
        S_FRONT_RD,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic head_null;
        logic free_null;
        logic walk_more;
        logic out_free;
    } t_dp_stat;

    // true when a link points at a real node
    function automatic logic is_node(input logic [LINK_W-1:0] link);
        return link < NULL_LINK;
    endfunction

endpackage

[sv/alfp_ctrl.sv]
// ----------------------------------------------------------------------------
// alfp_ctrl
// Sequencer that steps the datapath through one list command at a time
// ----------------------------------------------------------------------------
module alfp_ctrl
    import alfp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_back, n_back;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_back   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_back   <= n_back;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        n_back        = r_back;
        o_cmd.op      = OP_NONE;
        o_cmd.status  = r_status;
        o_s_tready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_status = ST_OK;
                    n_back   = 1'b0;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.cmd)
                    CMD_PUSH_FRONT: begin
                        if (i_stat.free_null) begin
                            n_status = ST_FULL;
                            n_state  = S_FRONT_RD;
                        end else begin
                            n_state  = S_TAKE_RD;
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (i_stat.head_null) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FRONT_RD;
                        end else begin
                            n_state  = S_POP_RD;
                        end
                    end
                    CMD_PUSH_BACK: begin
                        // an empty list makes this a push at the front
                        if (i_stat.free_null) begin
                            n_status = ST_FULL;
                            n_state  = S_FRONT_RD;
                        end else if (i_stat.head_null) begin
                            n_state  = S_TAKE_RD;
                        end else begin
                            n_back   = 1'b1;
                            n_state  = S_WALK_RD;
                        end
                    end
                    default: begin
                        n_state = S_FRONT_RD;
                    end
                endcase
            end
            S_TAKE_RD: begin
                o_cmd.op = OP_RD_FREE;
                n_state  = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                o_cmd.op = r_back ? OP_TAKE_BACK : OP_TAKE_FRONT;
                n_state  = r_back ? S_LINK : S_FRONT_RD;
            end
            S_POP_RD: begin
                o_cmd.op = OP_RD_HEAD;
                n_state  = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.op = OP_GIVE;
                n_state  = S_FRONT_RD;
            end
            S_WALK_RD: begin
                o_cmd.op = OP_WALK_START;
                n_state  = S_WALK;
            end
            S_WALK: begin
                o_cmd.op = OP_WALK_STEP;
                if (!i_stat.walk_more) begin
                    n_state = S_TAKE_RD;
                end
            end
            S_LINK: begin
                o_cmd.op = OP_LINK_LAST;
                n_state  = S_FRONT_RD;
            end
            S_FRONT_RD: begin
                o_cmd.op = OP_RD_FRONT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // an accepted beat always starts decoding next
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DECIDE))
        else $error("accepted beat did not move to decode");

    // a result is only loaded when the output stage can take it
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> i_stat.out_free)
        else $error("result loaded over a waiting result");

endmodule

[sv/alfp_dp.sv]
// ----------------------------------------------------------------------------
// alfp_dp
// Node store, head and free pointers, walk counter and output register
// ----------------------------------------------------------------------------
module alfp_dp
    import alfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [VALUE_W-1:0] i_s_tdata,   // [31:0] item_value
    input  logic [1:0]         i_s_tuser,   // [1:0] cmd
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [VALUE_W-1:0] o_m_tdata,   // [31:0] front_value
    output logic [2:0]         o_m_tuser    // [1:0] status, [2] front_valid
);

    // node store, contents valid only once written
    logic [VALUE_W-1:0] mem_value [NODE_COUNT];
    logic [LINK_W-1:0]  mem_link  [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_value_ok, r_link_ok;

    // pointers and captured beat
    logic [LINK_W-1:0]  r_head, n_head;
    logic [LINK_W-1:0]  r_free, n_free;
    logic [LINK_W-1:0]  r_last, n_last;
    logic [LINK_W-1:0]  r_new, n_new;
    logic [LINK_W-1:0]  r_steps, n_steps;
    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_val;

    // registered read port
    logic [LINK_W-1:0]  r_rd_addr;
    logic [VALUE_W-1:0] r_rd_value;
    logic [LINK_W-1:0]  r_rd_link;
    logic               r_rd_vok, r_rd_lok;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic               r_out_fvalid;
    logic [VALUE_W-1:0] r_out_value;

    // write and read requests
    logic               wr_value_en, wr_link_en, rd_en;
    logic [LINK_W-1:0]  wr_addr, rd_addr;
    logic [VALUE_W-1:0] wr_value;
    logic [LINK_W-1:0]  wr_link;

    // read data with never written entries shown at their reset contents
    logic [LINK_W-1:0]  rd_link, rd_link_norm;
    logic [VALUE_W-1:0] rd_value;
    logic               walk_more;

    assign rd_link      = r_rd_lok ? r_rd_link : r_rd_addr + LINK_W'(1);
    assign rd_value     = r_rd_vok ? r_rd_value : '0;
    assign rd_link_norm = is_node(rd_link) ? rd_link : NULL_LINK;
    assign walk_more    = is_node(rd_link) && (r_steps < NULL_LINK);

    // status towards the controller
    assign o_stat.cmd       = r_cmd;
    assign o_stat.head_null = !is_node(r_head);
    assign o_stat.free_null = !is_node(r_free);
    assign o_stat.walk_more = walk_more;
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    // operation decode
    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_last      = r_last;
        n_new       = r_new;
        n_steps     = r_steps;
        wr_value_en = 1'b0;
        wr_link_en  = 1'b0;
        wr_addr     = r_free;
        wr_value    = r_val;
        wr_link     = NULL_LINK;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        unique case (i_cmd.op)
            OP_RD_FREE: begin
                rd_en   = is_node(r_free);
                rd_addr = r_free;
            end
            OP_TAKE_FRONT: begin
                wr_value_en = 1'b1;
                wr_link_en  = 1'b1;
                wr_link     = r_head;
                n_free      = rd_link_norm;
                n_head      = r_free;
            end
            OP_TAKE_BACK: begin
                wr_value_en = 1'b1;
                wr_link_en  = 1'b1;
                wr_link     = NULL_LINK;
                n_free      = rd_link_norm;
                n_new       = r_free;
            end
            OP_RD_HEAD, OP_RD_FRONT: begin
                rd_en = is_node(r_head);
            end
            OP_GIVE: begin
                // old head goes back to the front of the free chain
                wr_value_en = 1'b1;
                wr_link_en  = 1'b1;
                wr_addr     = r_head;
                wr_value    = '0;
                wr_link     = r_free;
                n_free      = r_head;
                n_head      = rd_link_norm;
            end
            OP_WALK_START: begin
                rd_en   = is_node(r_head);
                n_last  = r_head;
                n_steps = '0;
            end
            OP_WALK_STEP: begin
                if (walk_more) begin
                    rd_en   = 1'b1;
                    rd_addr = rd_link;
                    n_last  = rd_link;
                    n_steps = r_steps + LINK_W'(1);
                end
            end
            OP_LINK_LAST: begin
                wr_link_en = 1'b1;
                wr_addr    = r_last;
                wr_link    = r_new;
            end
            default: begin
            end
        endcase
    end

    // pointers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= NULL_LINK;
            r_free     <= '0;
            r_value_ok <= '0;
            r_link_ok  <= '0;
        end else begin
            r_head <= n_head;
            r_free <= n_free;
            if (wr_value_en) begin
                r_value_ok[wr_addr[IDX_W-1:0]] <= 1'b1;
            end
            if (wr_link_en) begin
                r_link_ok[wr_addr[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_cmd   <= CMD_PUSH_FRONT;
        end else begin
            r_steps <= n_steps;
            if (i_cmd.op == OP_LOAD) begin
                r_cmd <= t_cmd'(i_s_tuser);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_new  <= n_new;
        if (i_cmd.op == OP_LOAD) begin
            r_val <= i_s_tdata;
        end
    end

    // node store write and read
    always_ff @(posedge i_clk) begin
        if (wr_value_en) begin
            mem_value[wr_addr[IDX_W-1:0]] <= wr_value;
        end
        if (wr_link_en) begin
            mem_link[wr_addr[IDX_W-1:0]] <= wr_link;
        end
        if (rd_en) begin
            r_rd_addr  <= rd_addr;
            r_rd_value <= mem_value[rd_addr[IDX_W-1:0]];
            r_rd_link  <= mem_link[rd_addr[IDX_W-1:0]];
            r_rd_vok   <= r_value_ok[rd_addr[IDX_W-1:0]];
            r_rd_lok   <= r_link_ok[rd_addr[IDX_W-1:0]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_out_status <= i_cmd.status;
            r_out_fvalid <= is_node(r_head);
            r_out_value  <= is_node(r_head) ? rd_value : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = {r_out_fvalid, r_out_status};

    // the head node is never also on the free chain
    a_head_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_node(r_head) |-> (r_head != r_free))
        else $error("head node is on the free chain");

    // pointers hold a node or null
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= NULL_LINK) && (r_free <= NULL_LINK))
        else $error("pointer out of range");

    // the walk is bounded by the node count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= NULL_LINK)
        else $error("walk ran past the node count");

endmodule

[sv/array_linked_list_free_pool.sv]
// ----------------------------------------------------------------------------
// array_linked_list_free_pool
// Singly linked list in a fixed node store with a chain of free nodes
// ----------------------------------------------------------------------------
// Input beats carry a command in s_tuser (push front, pop front, push back)
// and a 32-bit value in s_tdata. Each input beat yields exactly one output
// beat: status and front_valid in m_tuser, the value at the list head after
// the command in m_tdata (zero when the list is empty).
// Commands run one at a time through a sequencer over a single-port node
// store with registered reads. Push back first walks the node store, one
// link per cycle, to reach the tail (at most NODE_COUNT links followed).
// The next beat is accepted in the cycle after a result is loaded, even
// while that result still waits in the output register.
// Reset leaves an empty list with every node on the free chain, in order,
// with no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// command after it finishes up to its result, then waits for that register.
// ----------------------------------------------------------------------------
module array_linked_list_free_pool
    import alfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VALUE_W-1:0] i_s_tdata,   // [31:0] item_value
    input  logic [1:0]         i_s_tuser,   // [1:0] cmd
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [VALUE_W-1:0] o_m_tdata,   // [31:0] front_value
    output logic [2:0]         o_m_tuser    // [1:0] status, [2] front_valid
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    alfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // node store and pointers
    alfp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[test/array_linked_list_free_pool_tb.sv]
// ----------------------------------------------------------------------------
// array_linked_list_free_pool_tb
// Self-checking testbench for the linked list node pool
// ----------------------------------------------------------------------------
// A short table of commands covers an empty list, a full pool, the unused
// command code and the extreme values. A long random run follows, with the
// push to pop ratio swinging so that the list keeps reaching full and empty.
// Every result beat is checked field by field against a typed expectation or
// the testbench's copy of the list. The random run goes through phases with no
// idling, an idle sender, a stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module array_linked_list_free_pool_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import alfp_pkg::*;

    // command code with no operation behind it
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 300;
    localparam int SWING_ITEMS   = 48;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        t_status            status;
        logic               front_valid;
        logic [VALUE_W-1:0] front_value;
    } t_list_front;

    typedef struct {
        logic [1:0]         cmd;
        logic [VALUE_W-1:0] value;
        int                 reps;
        bit                 typed;
        t_status            exp_status;
        logic               exp_valid;
        logic [VALUE_W-1:0] exp_value;
    } t_stim_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [VALUE_W-1:0] i_s_tdata  = '0;   // [31:0] item_value
    logic [1:0]         i_s_tuser  = '0;   // [1:0] cmd
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [VALUE_W-1:0] o_m_tdata;         // [31:0] front_value
    logic [2:0]         o_m_tuser;         // [1:0] status, [2] front_valid

    // behavioural copy of the node store
    logic [VALUE_W-1:0] pool_value [NODE_COUNT];
    logic [LINK_W-1:0]  pool_link  [NODE_COUNT];
    logic [LINK_W-1:0]  list_head;
    logic [LINK_W-1:0]  free_head;

    t_list_front front_expect_q [$];
    int          error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // directed commands: typed expectations only where obvious
    t_stim_row directed_rows [14] = '{
        '{CMD_POP_FRONT,  32'h0000_0000,  1, 1'b1, ST_EMPTY, 1'b0, 32'h0000_0000},
        '{CMD_UNUSED,     32'hFFFF_FFFF,  1, 1'b1, ST_OK,    1'b0, 32'h0000_0000},
        '{CMD_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1, ST_OK,    1'b1, 32'h7FFF_FFFF},
        '{CMD_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, ST_OK,    1'b1, 32'h8000_0000},
        '{CMD_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b0, ST_OK,    1'b0, 32'h0000_0000},
        '{CMD_PUSH_FRONT, 32'h0000_0000,  1, 1'b1, ST_OK,    1'b1, 32'h0000_0000},
        '{CMD_POP_FRONT,  32'h0000_0000,  1, 1'b1, ST_OK,    1'b1, 32'h8000_0000},
        '{CMD_PUSH_BACK,  32'h5A5A_5A5A, 13, 1'b0, ST_OK,    1'b0, 32'h0000_0000},
        '{CMD_PUSH_FRONT, 32'h1234_5678,  1, 1'b1, ST_FULL,  1'b1, 32'h8000_0000},
        '{CMD_PUSH_BACK,  32'hA5A5_A5A5,  1, 1'b1, ST_FULL,  1'b1, 32'h8000_0000},
        '{CMD_UNUSED,     32'h0000_0000,  1, 1'b0, ST_OK,    1'b0, 32'h0000_0000},
        '{CMD_POP_FRONT,  32'h0000_0000, 16, 1'b0, ST_OK,    1'b0, 32'h0000_0000},
        '{CMD_POP_FRONT,  32'h0000_0000,  1, 1'b1, ST_EMPTY, 1'b0, 32'h0000_0000},
        '{CMD_PUSH_FRONT, 32'h0000_0001,  1, 1'b0, ST_OK,    1'b0, 32'h0000_0000}
    };

    array_linked_list_free_pool u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit is_pool_node(input logic [LINK_W-1:0] link);
        return link < NULL_LINK;
    endfunction

    // unlink the first free node and fill it in, null when none is left
    function automatic logic [LINK_W-1:0] take_free_node(input logic [VALUE_W-1:0] value,
                                                         input logic [LINK_W-1:0] link);
        logic [LINK_W-1:0] n;
        n = free_head;
        if (is_pool_node(n)) begin
            free_head = is_pool_node(pool_link[n[IDX_W-1:0]]) ?
                        pool_link[n[IDX_W-1:0]] : NULL_LINK;
            pool_value[n[IDX_W-1:0]] = value;
            pool_link[n[IDX_W-1:0]]  = link;
        end else begin
            n = NULL_LINK;
        end
        return n;
    endfunction

    function automatic t_status push_to_front(input logic [VALUE_W-1:0] value);
        logic [LINK_W-1:0] n;
        n = take_free_node(value, list_head);
        if (!is_pool_node(n))
            return ST_FULL;
        list_head = n;
        return ST_OK;
    endfunction

    // apply one command to the copy and return the result it gives
    function automatic t_list_front apply_list_command(input logic [1:0] cmd,
                                                       input logic [VALUE_W-1:0] value);
        t_list_front       res;
        t_status           st;
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] last;
        int                steps;
        st = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                st = push_to_front(value);
            end
            CMD_POP_FRONT: begin
                if (!is_pool_node(list_head)) begin
                    st = ST_EMPTY;
                end else begin
                    n         = list_head;
                    list_head = is_pool_node(pool_link[n[IDX_W-1:0]]) ?
                                pool_link[n[IDX_W-1:0]] : NULL_LINK;
                    pool_value[n[IDX_W-1:0]] = '0;
                    pool_link[n[IDX_W-1:0]]  = free_head;
                    free_head                = n;
                end
            end
            CMD_PUSH_BACK: begin
                if (!is_pool_node(list_head)) begin
                    st = push_to_front(value);
                end else begin
                    // walk to the tail, bounded by the pool size
                    last  = list_head;
                    steps = 0;
                    while (is_pool_node(pool_link[last[IDX_W-1:0]]) && steps < NODE_COUNT) begin
                        last = pool_link[last[IDX_W-1:0]];
                        steps++;
                    end
                    n = take_free_node(value, NULL_LINK);
                    if (!is_pool_node(n))
                        st = ST_FULL;
                    else
                        pool_link[last[IDX_W-1:0]] = n;
                end
            end
            default: ;
        endcase
        res.status      = st;
        res.front_valid = is_pool_node(list_head);
        res.front_value = res.front_valid ? pool_value[list_head[IDX_W-1:0]] : '0;
        return res;
    endfunction

    // value with a bias towards the extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // present one command beat and record what it should give
    task automatic send_command(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                                input bit typed, input t_list_front typed_front);
        t_list_front predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predicted = apply_list_command(cmd, value);
        if (typed)
            predicted = typed_front;
        front_expect_q.insert(front_expect_q.size(), predicted);
    endtask

    // receiver: random back-pressure and result check
    always @(posedge i_clk) begin
        t_list_front want;
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (front_expect_q.size() == 0) begin
                $error("result beat with nothing expected: status %0d front_value %h",
                       o_m_tuser[1:0], o_m_tdata);
                error_count++;
            end else begin
                want = front_expect_q[0];
                front_expect_q.delete(0);
                if (o_m_tuser[1:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_m_tuser[1:0]);
                    error_count++;
                end
                if (o_m_tuser[2] !== want.front_valid) begin
                    $error("front_valid: expected %0d, actual %0d",
                           want.front_valid, o_m_tuser[2]);
                    error_count++;
                end
                if (o_m_tdata !== want.front_value) begin
                    $error("front_value: expected %h, actual %h",
                           want.front_value, o_m_tdata);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_list_front typed_front;
        logic [1:0]  cmd;
        int          push_pct;
        // the copy starts as the block leaves reset
        for (int i = 0; i < NODE_COUNT; i++) begin
            pool_value[i] = '0;
            pool_link[i]  = LINK_W'(i + 1);
        end
        list_head = NULL_LINK;
        free_head = '0;
        push_pct  = 50;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling
        foreach (directed_rows[r]) begin
            typed_front.status      = directed_rows[r].exp_status;
            typed_front.front_valid = directed_rows[r].exp_valid;
            typed_front.front_value = directed_rows[r].exp_value;
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_command(directed_rows[r].cmd, directed_rows[r].value + VALUE_W'(k),
                             directed_rows[r].typed, typed_front);
        end

        // random phases: none, sender idle, receiver stall, both
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // swing between filling and draining the list
                if (i % SWING_ITEMS == 0)
                    push_pct = $urandom_range(1) ? 75 : 25;
                if ($urandom_range(99) < 3)
                    cmd = CMD_UNUSED;
                else if ($urandom_range(99) < push_pct)
                    cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    cmd = CMD_POP_FRONT;
                send_command(cmd, pick_value(), 1'b0, typed_front);
            end
        end
        i_s_tvalid <= 1'b0;

        // drain
        while (front_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
